// ===== src/rgps_pkg.sv =====
package rgps_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END     = 3'd4;

  localparam int CENTER_W = 18;
  localparam int INV_W    = 48;
  localparam int INV_HALF = 24;
  localparam int PIXEL_W  = 32;
  localparam int RGB_W    = 24;
  localparam int CHAN_W   = 8;

  // ratio in Q0.16 with room for exactly 1.0
  localparam int RATIO_W  = 17;
  localparam int FRAC_LSB = 40;
  localparam int SAT_BIT  = 56;
  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;

  // pipeline depth from request to result register
  localparam int STAGES = 7;

  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [CHAN_W-1:0]  chan_t;

endpackage

// ===== src/rgps_in_if.sv =====
interface rgps_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic                  last;

  modport source (output valid, output x, output y, output last, input ready);
  modport sink   (input valid, input x, input y, input last, output ready);
endinterface

// ===== src/rgps_out_if.sv =====
interface rgps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        span_end;

  modport source (output valid, output pixel, output span_end, input ready);
  modport sink   (input valid, input pixel, input span_end, output ready);
endinterface

// ===== src/rgps_blend.sv =====
module rgps_blend (
  input  rgps_pkg::chan_t  s,
  input  rgps_pkg::chan_t  e,
  input  rgps_pkg::ratio_t ratio,
  output rgps_pkg::chan_t  c
);
  localparam int PW = rgps_pkg::CHAN_W + rgps_pkg::RATIO_W;

  logic [PW-1:0] ps;
  logic [PW-1:0] pe;
  logic [PW-1:0] sum;

  // s*(1-t) + e*t never exceeds 255 * 2^16
  assign ps  = PW'(s) * PW'(rgps_pkg::ONE_Q16 - ratio);
  assign pe  = PW'(e) * PW'(ratio);
  assign sum = ps + pe;
  assign c   = sum[16 +: rgps_pkg::CHAN_W];
endmodule

// ===== src/radial_gradient_pixel_shader_unit.sv =====
// Radial gradient shader: one ARGB pixel per request, one request per clock
// sustained while the output is not stalled. The seven register stages are:
// offset from center and magnitude, the two squares, their sum, four partial
// products of the squared distance, split at bit 24, times the reciprocal, the
// middle partial sum, the final sum with clamp to 1.0, and the per-channel
// blend. Each stage holds its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up and requests keep entering while a
// finished pixel waits at the output, as long as some stage is still empty.
// Configuration is read live and should only change while the pipe is empty.
module radial_gradient_pixel_shader_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rgps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgps_pkg::CFG_DATA_W-1:0] cfg_data,
  rgps_in_if.sink                         pix_in,
  rgps_out_if.source                      pix_out
);
  localparam int NS   = rgps_pkg::STAGES;
  localparam int PW   = COORD_BITS + 4;
  localparam int DW   = (PW > rgps_pkg::CENTER_W - 1) ? PW + 2 : rgps_pkg::CENTER_W + 1;
  localparam int MW   = DW - 1;
  localparam int SW   = 2 * MW;
  localparam int D2W  = SW + 1;
  localparam int HW   = rgps_pkg::INV_HALF;
  localparam int PLW  = 2 * HW;
  localparam int MIDW = PLW + 1;
  localparam int TW   = D2W + rgps_pkg::INV_W + 1;

  // configuration registers
  logic [rgps_pkg::CENTER_W-1:0] center_x;
  logic [rgps_pkg::CENTER_W-1:0] center_y;
  logic [rgps_pkg::INV_W-1:0]    inv_radius_sq;
  logic [rgps_pkg::PIXEL_W-1:0]  color_start;
  logic [rgps_pkg::RGB_W-1:0]    color_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      inv_radius_sq <= '0;
      color_start   <= '0;
      color_end     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgps_pkg::CFG_CENTER_X:      center_x      <= cfg_data[rgps_pkg::CENTER_W-1:0];
        rgps_pkg::CFG_CENTER_Y:      center_y      <= cfg_data[rgps_pkg::CENTER_W-1:0];
        rgps_pkg::CFG_INV_RADIUS_SQ: inv_radius_sq <= cfg_data[rgps_pkg::INV_W-1:0];
        rgps_pkg::CFG_COLOR_START:   color_start   <= cfg_data[rgps_pkg::PIXEL_W-1:0];
        rgps_pkg::CFG_COLOR_END:     color_end     <= cfg_data[rgps_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] vld;
  logic [NS-1:0] load;
  logic [NS-1:0] last_pipe;

  always_comb begin
    load[NS-1] = !vld[NS-1] || pix_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= pix_in.valid;
      for (int i = 1; i < NS; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) last_pipe[0] <= pix_in.last;
    for (int i = 1; i < NS; i++) begin
      if (load[i]) last_pipe[i] <= last_pipe[i-1];
    end
  end

  assign pix_in.ready = load[0];

  // stage 1: offset from center and its magnitude
  logic signed [DW-1:0] px16;
  logic signed [DW-1:0] py16;
  logic signed [DW-1:0] cx_ext;
  logic signed [DW-1:0] cy_ext;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        ax;
  logic [DW-1:0]        ay;
  logic [MW-1:0]        s1_mag_x;
  logic [MW-1:0]        s1_mag_y;

  assign px16   = {{(DW-PW){1'b0}}, pix_in.x, 4'b0000};
  assign py16   = {{(DW-PW){1'b0}}, pix_in.y, 4'b0000};
  assign cx_ext = {{(DW-rgps_pkg::CENTER_W){center_x[rgps_pkg::CENTER_W-1]}}, center_x};
  assign cy_ext = {{(DW-rgps_pkg::CENTER_W){center_y[rgps_pkg::CENTER_W-1]}}, center_y};
  assign dx     = px16 - cx_ext;
  assign dy     = py16 - cy_ext;
  assign ax     = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay     = dy[DW-1] ? DW'(-dy) : DW'(dy);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_mag_x <= ax[MW-1:0];
      s1_mag_y <= ay[MW-1:0];
    end
  end

  // stage 2: squares
  logic [SW-1:0] s2_sq_x;
  logic [SW-1:0] s2_sq_y;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_sq_x <= SW'(s1_mag_x) * SW'(s1_mag_x);
      s2_sq_y <= SW'(s1_mag_y) * SW'(s1_mag_y);
    end
  end

  // stage 3: squared distance
  logic [D2W-1:0] s3_d2;

  always_ff @(posedge clk) begin
    if (load[2]) s3_d2 <= {1'b0, s2_sq_x} + {1'b0, s2_sq_y};
  end

  // stage 4: partial products of d2 times the reciprocal
  logic [PLW-1:0] s4_pll;
  logic [PLW-1:0] s4_plh;
  logic [D2W-1:0] s4_phl;
  logic [D2W-1:0] s4_phh;
  logic [HW-1:0]     d2_lo;
  logic [D2W-HW-1:0] d2_hi;
  logic [HW-1:0]     inv_lo;
  logic [HW-1:0]     inv_hi;

  assign d2_lo  = s3_d2[HW-1:0];
  assign d2_hi  = s3_d2[D2W-1:HW];
  assign inv_lo = inv_radius_sq[HW-1:0];
  assign inv_hi = inv_radius_sq[rgps_pkg::INV_W-1:HW];

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_pll <= PLW'(d2_lo) * PLW'(inv_lo);
      s4_plh <= PLW'(d2_lo) * PLW'(inv_hi);
      s4_phl <= D2W'(d2_hi) * D2W'(inv_lo);
      s4_phh <= D2W'(d2_hi) * D2W'(inv_hi);
    end
  end

  // stage 5: the two middle products share a weight
  logic [PLW-1:0]  s5_pll;
  logic [MIDW-1:0] s5_mid;
  logic [D2W-1:0]  s5_phh;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_pll <= s4_pll;
      s5_mid <= {1'b0, s4_plh} + MIDW'(s4_phl);
      s5_phh <= s4_phh;
    end
  end

  // stage 6: full product, clamp at 1.0
  logic [TW-1:0]         total;
  logic                  sat;
  rgps_pkg::ratio_t      s6_ratio;

  assign total = TW'(s5_pll) + (TW'(s5_mid) << HW) + (TW'(s5_phh) << PLW);
  assign sat   = |total[TW-1:rgps_pkg::SAT_BIT];

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_ratio <= sat ? rgps_pkg::ONE_Q16
                      : {1'b0, total[rgps_pkg::SAT_BIT-1:rgps_pkg::FRAC_LSB]};
    end
  end

  // stage 7: channel blend into the result register
  rgps_pkg::chan_t r_c;
  rgps_pkg::chan_t g_c;
  rgps_pkg::chan_t b_c;
  logic [rgps_pkg::PIXEL_W-1:0] pix_r;

  rgps_blend u_blend_r (
    .s(color_start[23:16]), .e(color_end[23:16]), .ratio(s6_ratio), .c(r_c)
  );
  rgps_blend u_blend_g (
    .s(color_start[15:8]), .e(color_end[15:8]), .ratio(s6_ratio), .c(g_c)
  );
  rgps_blend u_blend_b (
    .s(color_start[7:0]), .e(color_end[7:0]), .ratio(s6_ratio), .c(b_c)
  );

  always_ff @(posedge clk) begin
    if (load[6]) pix_r <= {color_start[31:24], r_c, g_c, b_c};
  end

  assign pix_out.valid    = vld[NS-1];
  assign pix_out.pixel    = pix_r;
  assign pix_out.span_end = last_pipe[NS-1];

  // an empty output stage means the whole chain can take a request
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NS-1] |-> pix_in.ready)
    else $error("input stalled with an empty output stage");

  // an accepted request always lands in the first stage
  a_request_captured: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> vld[0])
    else $error("accepted request not held in stage one");

  // the clamped ratio never exceeds 1.0
  a_ratio_bounded: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (s6_ratio <= rgps_pkg::ONE_Q16))
    else $error("ratio above one");

endmodule
